// ===== rtl/core/rk4_pkg.sv =====
`default_nettype none

package rk4_pkg;

	localparam int MAX_VARS = 16;
	localparam int IDX_W    = 4;
	localparam int VAL_W    = 32;
	localparam int STEP_W   = 31;
	localparam int CNT_W    = 5;
	localparam int CFG_IDX_W = 1;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [STEP_W-1:0] STEP_SIZE_RESET = 31'd65536;
	localparam logic [CNT_W-1:0]  VAR_COUNT_RESET = 5'd1;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VAR_COUNT = 1'd1;

	// width of a clamped h*k term; anything beyond it saturates every sum anyway
	localparam int TERM_W = 37;

	localparam logic signed [63:0] RND_SIXTH = 64'sd196608;
	localparam logic signed [63:0] RND_THIRD = 64'sd98304;
	localparam logic signed [63:0] RND_HALF  = 64'sd65536;
	localparam logic signed [63:0] RND_WHOLE = 64'sd32768;

	// floor(u/3) = a*349525 + floor((a+b)/3) with u = a*2^20 + b
	localparam int                DIV3_SPLIT   = 20;
	localparam logic [36:0]       DIV3_HI_MUL  = 37'd349525;
	localparam logic [42:0]       DIV3_RECIP   = 43'd2796203;
	localparam logic [37:0]       DIV3_BIAS    = 38'd206158430208;
	localparam logic signed [37:0] DIV3_OFFSET = 38'sd68719476736;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef enum logic [0:0] {
		OP_LOAD  = 1'b0,
		OP_DERIV = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_MID1  = 2'd0,
		KIND_MID2  = 2'd1,
		KIND_END   = 2'd2,
		KIND_FINAL = 2'd3
	} kind_t;

	typedef struct packed {
		op_t                      op;
		logic [IDX_W-1:0]         idx;
		logic signed [VAL_W-1:0]  val;
		kind_t                    kind;
		logic                     last;
		logic signed [VAL_W-1:0]  tm;
	} cmd_t;

	function automatic logic signed [31:0] sat_33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'(S32_MAX)) begin
			r = S32_MAX;
		end else if (v < 33'(S32_MIN)) begin
			r = S32_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat_38(input logic signed [37:0] v);
		logic signed [31:0] r;
		if (v > 38'(S32_MAX)) begin
			r = S32_MAX;
		end else if (v < 38'(S32_MIN)) begin
			r = S32_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [TERM_W-1:0] clamp_term(input logic signed [47:0] v);
		logic signed [TERM_W-1:0] r;
		logic signed [47:0]       hi;
		logic signed [47:0]       lo;
		hi = 48'sd68719476735;
		lo = -48'sd68719476736;
		if (v > hi) begin
			r = hi[TERM_W-1:0];
		end else if (v < lo) begin
			r = lo[TERM_W-1:0];
		end else begin
			r = v[TERM_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rk4_queue.sv =====
`default_nettype none

module rk4_queue import rk4_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t din,
	output logic      full,
	input  wire logic pop,
	output cmd_t      dout,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t           mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PW'(1);
		end
		return r;
	endfunction

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rk4_front.sv =====
`default_nettype none

module rk4_front import rk4_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    opcode,
	input  wire logic [IDX_W-1:0]        elem_index,
	input  wire logic signed [VAL_W-1:0] elem_value,
	input  wire logic signed [VAL_W-1:0] start_time,
	input  wire logic [STEP_W-1:0]       step_size,
	input  wire logic [CNT_W-1:0]        var_count,
	input  wire logic                    q_full,
	output logic                         q_push,
	output cmd_t                         q_din
);

	kind_t                   stage_q;
	logic signed [VAL_W-1:0] step_time_q;

	logic [CNT_W-1:0]        cnt_eff;
	logic                    last;
	logic                    latch_time;
	logic signed [VAL_W-1:0] time_base;
	logic [STEP_W:0]         size_inc;
	logic [STEP_W-1:0]       incr;
	logic signed [VAL_W:0]   time_sum;

	always_comb begin
		if (var_count == '0) begin
			cnt_eff = CNT_W'(1);
		end else if (var_count > CNT_W'(MAX_VARS)) begin
			cnt_eff = CNT_W'(MAX_VARS);
		end else begin
			cnt_eff = var_count;
		end
		last       = (CNT_W'(elem_index) == (cnt_eff - CNT_W'(1)));
		latch_time = (opcode == OP_DERIV) && (stage_q == KIND_MID1) && (elem_index == '0);
		time_base  = latch_time ? start_time : step_time_q;
		size_inc   = {1'b0, step_size} + (STEP_W + 1)'(1);
		if ((stage_q == KIND_MID1) || (stage_q == KIND_MID2)) begin
			incr = size_inc[STEP_W:1];
		end else begin
			incr = step_size;
		end
		time_sum = {time_base[VAL_W-1], time_base} + $signed({2'b00, incr});
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_din.op   = op_t'(opcode);
		q_din.idx  = elem_index;
		q_din.val  = elem_value;
		q_din.kind = stage_q;
		q_din.last = last;
		q_din.tm   = sat_33(time_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= KIND_MID1;
			step_time_q <= '0;
		end else if (q_push && (opcode == OP_DERIV)) begin
			if (latch_time) begin
				step_time_q <= start_time;
			end
			if (last) begin
				stage_q <= kind_t'(stage_q + 2'd1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rk4_back.sv =====
`default_nettype none

module rk4_back import rk4_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [STEP_W-1:0]   step_size,
	input  wire logic                q_empty,
	input  wire cmd_t                q_dout,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [VAL_W-1:0]  point_value,
	output logic [IDX_W-1:0]         point_index,
	output logic signed [VAL_W-1:0]  point_time,
	output logic [1:0]               point_kind,
	output logic                     last_element
);

	logic en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	cmd_t cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5;

	logic signed [63:0]        prod_s1;
	logic signed [TERM_W-1:0]  md_s2, me_s2, me_s3, me_s4, te_s5, td_s5;
	logic [36:0]               pa_s3, pa_s4;
	logic [20:0]               sum_s3;
	logic [19:0]               qs_s4;

	logic signed [VAL_W-1:0]   state_q [MAX_VARS];
	logic signed [VAL_W-1:0]   wsum_q  [MAX_VARS];

	logic                      out_valid_q;
	logic signed [VAL_W-1:0]   point_value_q;
	logic [IDX_W-1:0]          point_index_q;
	logic signed [VAL_W-1:0]   point_time_q;
	logic [1:0]                point_kind_q;
	logic                      last_element_q;

	logic signed [63:0]        mul;
	logic                      sixth;
	logic signed [63:0]        nd, ne, shd, she;
	logic [37:0]               u;
	logic [17:0]               div_a;
	logic [19:0]               div_b;
	logic [42:0]               recip_prod;
	logic signed [37:0]        third;
	logic signed [VAL_W-1:0]   x, ws, wbase, pbase, wnew, pnew;
	logic signed [TERM_W-1:0]  pterm;

	assign en    = !out_valid_q || !out_stall;
	assign q_pop = en && !q_empty;

	// stage 1: h*k
	assign mul = $signed({1'b0, step_size}) * $signed(q_dout.val);

	// stage 2: round and scale by 1/2, 1/6 (via /2 then /3), 1/3 or 1
	always_comb begin
		sixth = (cmd_s1.kind == KIND_MID1) || (cmd_s1.kind == KIND_FINAL);
		nd    = prod_s1 + (sixth ? RND_SIXTH : RND_THIRD);
		shd   = sixth ? (nd >>> 17) : (nd >>> 16);
		ne    = prod_s1 + ((cmd_s1.kind == KIND_END) ? RND_WHOLE : RND_HALF);
		she   = (cmd_s1.kind == KIND_END) ? (ne >>> 16) : (ne >>> 17);
	end

	// stage 3: split the biased dividend
	always_comb begin
		u     = {md_s2[TERM_W-1], md_s2} + DIV3_BIAS;
		div_a = u[37:DIV3_SPLIT];
		div_b = u[DIV3_SPLIT-1:0];
	end

	// stage 4: low part divided by three through its reciprocal
	assign recip_prod = 43'(sum_s3) * DIV3_RECIP;

	// stage 5: reassemble the quotient
	assign third = $signed({1'b0, pa_s4}) + $signed({18'b0, qs_s4}) - DIV3_OFFSET;

	// final stage: read, combine and write back
	always_comb begin
		x     = state_q[cmd_s5.idx];
		ws    = wsum_q[cmd_s5.idx];
		wbase = (cmd_s5.kind == KIND_MID1) ? x : ws;
		pbase = (cmd_s5.kind == KIND_FINAL) ? ws : x;
		pterm = (cmd_s5.kind == KIND_FINAL) ? td_s5 : te_s5;
		wnew  = sat_38({{6{wbase[VAL_W-1]}}, wbase} + {td_s5[TERM_W-1], td_s5});
		pnew  = sat_38({{6{pbase[VAL_W-1]}}, pbase} + {pterm[TERM_W-1], pterm});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= !q_empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5 && (cmd_s5.op == OP_DERIV);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= q_dout;
			prod_s1 <= mul;
			cmd_s2  <= cmd_s1;
			md_s2   <= clamp_term(shd[47:0]);
			me_s2   <= clamp_term(she[47:0]);
			cmd_s3  <= cmd_s2;
			pa_s3   <= 37'(div_a) * DIV3_HI_MUL;
			sum_s3  <= 21'(div_a) + 21'(div_b);
			me_s3   <= me_s2;
			cmd_s4  <= cmd_s3;
			pa_s4   <= pa_s3;
			qs_s4   <= recip_prod[42:23];
			me_s4   <= me_s3;
			cmd_s5  <= cmd_s4;
			td_s5   <= third[TERM_W-1:0];
			te_s5   <= me_s4;
			if (v_s5 && (cmd_s5.op == OP_DERIV)) begin
				point_value_q  <= pnew;
				point_index_q  <= cmd_s5.idx;
				point_time_q   <= cmd_s5.tm;
				point_kind_q   <= cmd_s5.kind;
				last_element_q <= cmd_s5.last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VARS; i++) begin
				state_q[i] <= '0;
			end
		end else if (en && v_s5) begin
			if (cmd_s5.op == OP_LOAD) begin
				state_q[cmd_s5.idx] <= cmd_s5.val;
			end else if (cmd_s5.kind == KIND_FINAL) begin
				state_q[cmd_s5.idx] <= pnew;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s5 && (cmd_s5.op == OP_DERIV) && (cmd_s5.kind != KIND_FINAL)) begin
			wsum_q[cmd_s5.idx] <= wnew;
		end
	end

	assign out_valid    = out_valid_q;
	assign point_value  = point_value_q;
	assign point_index  = point_index_q;
	assign point_time   = point_time_q;
	assign point_kind   = point_kind_q;
	assign last_element = last_element_q;

endmodule

`default_nettype wire

// ===== rtl/core/rk4_step_combiner.sv =====
// channel  | handshake             | request
// ---------+-----------------------+-----------------------------------------------
// in       | in_valid / in_stall   | opcode, elem_index, elem_value, start_time
// out      | out_valid / out_stall | point_value, point_index, point_time,
//          |                       | point_kind, last_element
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low. A derivative request
// raises out_valid after the queue slot and multiply, rounding, split, reciprocal
// divide by three, reassembly and read-modify-write into the output register.
// Reset: h = 1.0, var_count = 1, state zero, stage one, step time zero.
// out_stall freezes the back pipeline while out_valid is high; the 4-entry queue
// takes requests until it fills, then in_stall rises. cfg_ready is always high.
`default_nettype none

module rk4_step_combiner import rk4_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    opcode,
	input  wire logic [IDX_W-1:0]        elem_index,
	input  wire logic signed [VAL_W-1:0] elem_value,
	input  wire logic signed [VAL_W-1:0] start_time,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [VAL_W-1:0]      point_value,
	output logic [IDX_W-1:0]             point_index,
	output logic signed [VAL_W-1:0]      point_time,
	output logic [1:0]                   point_kind,
	output logic                         last_element,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [STEP_W-1:0]       cfg_data
);

	logic [STEP_W-1:0] step_size_q;
	logic [CNT_W-1:0]  var_count_q;

	logic q_full, q_push, q_pop, q_empty;
	cmd_t q_din, q_dout;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q <= STEP_SIZE_RESET;
			var_count_q <= VAR_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STEP_SIZE: step_size_q <= cfg_data;
				REG_VAR_COUNT: var_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	rk4_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.elem_index (elem_index),
		.elem_value (elem_value),
		.start_time (start_time),
		.step_size  (step_size_q),
		.var_count  (var_count_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_din      (q_din)
	);

	rk4_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	rk4_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_size    (step_size_q),
		.q_empty      (q_empty),
		.q_dout       (q_dout),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.point_value  (point_value),
		.point_index  (point_index),
		.point_time   (point_time),
		.point_kind   (point_kind),
		.last_element (last_element)
	);

endmodule

`default_nettype wire
